// File: rtl/core/cgt_pkg.sv
// shared constants and types for the complex gemm 2x2 tile mac
`timescale 1ns / 1ps
`default_nettype none

package cgt_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int ACC_WIDTH_DEF  = 48;
    localparam int PRIOR_W        = 48;
    localparam int OUT_W          = 48;
    localparam int QUEUE_DEPTH    = 4;
    localparam int CFG_AW         = 4;
    localparam int CFG_DW         = 32;

    // register indexes, byte address is 4 * index
    localparam logic [1:0] REG_ACCUM = 2'd0;
    localparam logic [1:0] REG_ROWS  = 2'd1;
    localparam logic [1:0] REG_COLS  = 2'd2;

    typedef struct packed {
        logic is_prior;
        logic last;
    } t_step_ctl;

    typedef struct packed {
        logic accum;
        logic rows2;
        logic cols2;
    } t_tile_cfg;

endpackage

`default_nettype wire

// File: rtl/core/cgt_ifs.sv
// step and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface cgt_step_if #(
    parameter int DATA_WIDTH = cgt_pkg::DATA_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic signed [DATA_WIDTH-1:0]  a0_re;
    logic signed [DATA_WIDTH-1:0]  a0_im;
    logic signed [DATA_WIDTH-1:0]  a1_re;
    logic signed [DATA_WIDTH-1:0]  a1_im;
    logic signed [DATA_WIDTH-1:0]  b0_re;
    logic signed [DATA_WIDTH-1:0]  b0_im;
    logic signed [DATA_WIDTH-1:0]  b1_re;
    logic signed [DATA_WIDTH-1:0]  b1_im;
    logic                          last_step;
    logic signed [cgt_pkg::PRIOR_W-1:0] prior_re;
    logic signed [cgt_pkg::PRIOR_W-1:0] prior_im;

    modport source (
        output valid, req_type, a0_re, a0_im, a1_re, a1_im,
               b0_re, b0_im, b1_re, b1_im, last_step, prior_re, prior_im,
        input  ready
    );
    modport sink (
        input  valid, req_type, a0_re, a0_im, a1_re, a1_im,
               b0_re, b0_im, b1_re, b1_im, last_step, prior_re, prior_im,
        output ready
    );
endinterface

interface cgt_res_if;
    logic                             valid;
    logic                             ready;
    logic                             row_index;
    logic                             col_index;
    logic signed [cgt_pkg::OUT_W-1:0] out_re;
    logic signed [cgt_pkg::OUT_W-1:0] out_im;
    logic                             tile_done;

    modport source (
        output valid, row_index, col_index, out_re, out_im, tile_done,
        input  ready
    );
    modport sink (
        input  valid, row_index, col_index, out_re, out_im, tile_done,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/cgt_front.sv
// front end: accepts step beats, classifies them and queues them for the back end
`timescale 1ns / 1ps
`default_nettype none

module cgt_front #(
    parameter int DATA_WIDTH = cgt_pkg::DATA_WIDTH_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    cgt_step_if.sink                          i_step,
    output logic                              o_q_valid,
    input  wire                               i_q_ready,
    output cgt_pkg::t_step_ctl                o_q_ctl,
    output logic [7:0][DATA_WIDTH-1:0]        o_q_ops,
    output logic [cgt_pkg::PRIOR_W-1:0]       o_q_prior_re,
    output logic [cgt_pkg::PRIOR_W-1:0]       o_q_prior_im
);
    import cgt_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    logic [7:0][DATA_WIDTH-1:0] r_ops [QUEUE_DEPTH];
    t_step_ctl                  r_ctl [QUEUE_DEPTH];
    logic [PRIOR_W-1:0]         r_pre [QUEUE_DEPTH];
    logic [PRIOR_W-1:0]         r_pim [QUEUE_DEPTH];

    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [AW:0]   r_count,  n_count;

    logic                       w_wr;
    logic                       w_rd;
    t_step_ctl                  w_ctl;
    logic [7:0][DATA_WIDTH-1:0] w_ops;

    // operand fields only matter on a step, last flag too
    assign w_ctl.is_prior = i_step.req_type;
    assign w_ctl.last     = i_step.last_step & ~i_step.req_type;
    assign w_ops = {i_step.b1_im, i_step.b1_re, i_step.b0_im, i_step.b0_re,
                    i_step.a1_im, i_step.a1_re, i_step.a0_im, i_step.a0_re};

    assign i_step.ready = (r_count != (AW+1)'(QUEUE_DEPTH));
    assign w_wr = i_step.valid & i_step.ready;

    assign o_q_valid    = (r_count != '0);
    assign w_rd         = o_q_valid & i_q_ready;
    assign o_q_ctl      = r_ctl[r_rd_ptr];
    assign o_q_ops      = r_ops[r_rd_ptr];
    assign o_q_prior_re = r_pre[r_rd_ptr];
    assign o_q_prior_im = r_pim[r_rd_ptr];

    always_comb begin
        n_wr_ptr = w_wr ? r_wr_ptr + AW'(1) : r_wr_ptr;
        n_rd_ptr = w_rd ? r_rd_ptr + AW'(1) : r_rd_ptr;
        n_count  = r_count + (AW+1)'(w_wr) - (AW+1)'(w_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_ops[r_wr_ptr] <= w_ops;
            r_ctl[r_wr_ptr] <= w_ctl;
            r_pre[r_wr_ptr] <= i_step.prior_re;
            r_pim[r_wr_ptr] <= i_step.prior_im;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/cgt_back.sv
// back end: product stage, saturating tile accumulators, emit sequencer, output register
`timescale 1ns / 1ps
`default_nettype none

module cgt_back #(
    parameter int DATA_WIDTH = cgt_pkg::DATA_WIDTH_DEF,
    parameter int ACC_WIDTH  = cgt_pkg::ACC_WIDTH_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire cgt_pkg::t_tile_cfg           i_cfg,
    input  wire                               i_q_valid,
    output logic                              o_q_ready,
    input  wire cgt_pkg::t_step_ctl           i_q_ctl,
    input  wire [7:0][DATA_WIDTH-1:0]         i_q_ops,
    input  wire [cgt_pkg::PRIOR_W-1:0]        i_q_prior_re,
    input  wire [cgt_pkg::PRIOR_W-1:0]        i_q_prior_im,
    cgt_res_if.source                         o_res
);
    import cgt_pkg::*;

    localparam int PW  = 2 * DATA_WIDTH;
    localparam int MW1 = (ACC_WIDTH > PW) ? ACC_WIDTH : PW;
    localparam int MW  = (MW1 > PRIOR_W) ? MW1 : PRIOR_W;
    localparam int SW  = MW + 2;
    localparam int FW  = (ACC_WIDTH > OUT_W) ? ACC_WIDTH : OUT_W;

    localparam logic signed [SW-1:0] ACC_MAX =
        {{(SW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] ACC_MIN = ~ACC_MAX;

    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_AWAIT = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    function automatic logic signed [ACC_WIDTH-1:0] sat(input logic signed [SW-1:0] v);
        if (v > ACC_MAX)
            sat = ACC_MAX[ACC_WIDTH-1:0];
        else if (v < ACC_MIN)
            sat = ACC_MIN[ACC_WIDTH-1:0];
        else
            sat = v[ACC_WIDTH-1:0];
    endfunction

    function automatic logic signed [ACC_WIDTH-1:0] sat_add(
        input logic signed [ACC_WIDTH-1:0] a,
        input logic signed [SW-1:0]        b
    );
        sat_add = sat(SW'(a) + b);
    endfunction

    function automatic logic [OUT_W-1:0] fmt(input logic signed [ACC_WIDTH-1:0] v);
        logic signed [FW-1:0] t;
        t   = FW'(v);
        fmt = t[OUT_W-1:0];
    endfunction

    // position in row-major order to element {row, col}
    function automatic logic [1:0] elem_of(input logic [1:0] p, input logic cols2);
        elem_of = cols2 ? p : {p[0], 1'b0};
    endfunction

    // ---------------- product stage ----------------
    logic signed [DATA_WIDTH-1:0] w_ar [2];
    logic signed [DATA_WIDTH-1:0] w_ai [2];
    logic signed [DATA_WIDTH-1:0] w_br [2];
    logic signed [DATA_WIDTH-1:0] w_bi [2];
    logic signed [PW-1:0] w_p_rr [4];
    logic signed [PW-1:0] w_p_ii [4];
    logic signed [PW-1:0] w_p_ir [4];
    logic signed [PW-1:0] w_p_ri [4];

    logic                 r_m_valid;
    t_step_ctl            r_m_ctl;
    logic signed [PW-1:0] r_p_rr [4];
    logic signed [PW-1:0] r_p_ii [4];
    logic signed [PW-1:0] r_p_ir [4];
    logic signed [PW-1:0] r_p_ri [4];
    logic [PRIOR_W-1:0]   r_m_pre;
    logic [PRIOR_W-1:0]   r_m_pim;

    logic w_m_ready;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            w_ar[i] = $signed(i_q_ops[2*i]);
            w_ai[i] = $signed(i_q_ops[2*i+1]);
            w_br[i] = $signed(i_q_ops[4+2*i]);
            w_bi[i] = $signed(i_q_ops[5+2*i]);
        end
        for (int r = 0; r < 2; r++) begin
            for (int c = 0; c < 2; c++) begin
                w_p_rr[2*r+c] = w_ar[r] * w_br[c];
                w_p_ii[2*r+c] = w_ai[r] * w_bi[c];
                w_p_ir[2*r+c] = w_ai[r] * w_br[c];
                w_p_ri[2*r+c] = w_ar[r] * w_bi[c];
            end
        end
    end

    assign o_q_ready = w_m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_m_ready) begin
            r_m_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_m_ready) begin
            r_m_ctl <= i_q_ctl;
            r_m_pre <= i_q_prior_re;
            r_m_pim <= i_q_prior_im;
            for (int e = 0; e < 4; e++) begin
                r_p_rr[e] <= w_p_rr[e];
                r_p_ii[e] <= w_p_ii[e];
                r_p_ir[e] <= w_p_ir[e];
                r_p_ri[e] <= w_p_ri[e];
            end
        end
    end

    // ---------------- accumulate and emit stage ----------------
    logic signed [ACC_WIDTH-1:0] r_acc_re [4];
    logic signed [ACC_WIDTH-1:0] r_acc_im [4];
    logic signed [ACC_WIDTH-1:0] n_acc_re [4];
    logic signed [ACC_WIDTH-1:0] n_acc_im [4];
    logic [1:0] r_state, n_state;
    logic [1:0] r_pos,   n_pos;
    logic [1:0] r_k,     n_k;

    logic             r_o_valid, n_o_valid;
    logic             r_o_row,   n_o_row;
    logic             r_o_col,   n_o_col;
    logic [OUT_W-1:0] r_o_re,    n_o_re;
    logic [OUT_W-1:0] r_o_im,    n_o_im;
    logic             r_o_done,  n_o_done;

    logic       w_out_free;
    logic       w_need_out;
    logic       w_take;
    logic       w_mul_fire;
    logic       w_prior_fire;
    logic       w_drain_fire;
    logic [2:0] w_count;
    logic [2:0] w_cm1;
    logic [1:0] w_pos_eff;
    logic       w_prior_last;
    logic       w_drain_last;
    logic [1:0] w_sel_pos;
    logic [1:0] w_e;
    logic       w_en [4];

    assign w_out_free = ~r_o_valid | o_res.ready;
    assign w_need_out = r_m_ctl.is_prior & (r_state == ST_AWAIT);
    assign w_take     = r_m_valid & (r_state != ST_DRAIN) & (~w_need_out | w_out_free);
    assign w_m_ready  = ~r_m_valid | w_take;

    assign w_mul_fire   = w_take & ~r_m_ctl.is_prior & (r_state == ST_RUN);
    assign w_prior_fire = w_take & w_need_out;
    assign w_drain_fire = (r_state == ST_DRAIN) & w_out_free;

    always_comb begin
        if (i_cfg.rows2 & i_cfg.cols2)
            w_count = 3'd4;
        else if (i_cfg.rows2 | i_cfg.cols2)
            w_count = 3'd2;
        else
            w_count = 3'd1;
        w_cm1 = w_count - 3'd1;
        // a position past the used count falls back to the last used element
        w_pos_eff    = ({1'b0, r_pos} >= w_count) ? w_cm1[1:0] : r_pos;
        w_prior_last = (({1'b0, w_pos_eff} + 3'd1) == w_count);
        w_drain_last = (({1'b0, r_k} + 3'd1) == w_count);
        w_sel_pos    = (r_state == ST_DRAIN) ? r_k : w_pos_eff;
        w_e          = elem_of(w_sel_pos, i_cfg.cols2);
        for (int e = 0; e < 4; e++) begin
            w_en[e] = (e < 2 || i_cfg.rows2) && ((e % 2) == 0 || i_cfg.cols2);
        end
    end

    always_comb begin
        n_acc_re  = r_acc_re;
        n_acc_im  = r_acc_im;
        n_state   = r_state;
        n_pos     = r_pos;
        n_k       = r_k;
        n_o_valid = r_o_valid & ~o_res.ready;
        n_o_row   = r_o_row;
        n_o_col   = r_o_col;
        n_o_re    = r_o_re;
        n_o_im    = r_o_im;
        n_o_done  = r_o_done;

        if (w_mul_fire) begin
            for (int e = 0; e < 4; e++) begin
                if (w_en[e]) begin
                    n_acc_re[e] = sat_add(sat_add(r_acc_re[e], SW'(r_p_rr[e])),
                                          -SW'(r_p_ii[e]));
                    n_acc_im[e] = sat_add(sat_add(r_acc_im[e], SW'(r_p_ir[e])),
                                          SW'(r_p_ri[e]));
                end
            end
            if (r_m_ctl.last) begin
                if (i_cfg.accum) begin
                    n_state = ST_AWAIT;
                    n_pos   = 2'd0;
                end else begin
                    n_state = ST_DRAIN;
                    n_k     = 2'd0;
                end
            end
        end

        if (w_prior_fire) begin
            n_o_valid = 1'b1;
            n_o_row   = w_e[1];
            n_o_col   = w_e[0];
            n_o_re    = fmt(sat_add(r_acc_re[w_e], SW'($signed(r_m_pre))));
            n_o_im    = fmt(sat_add(r_acc_im[w_e], SW'($signed(r_m_pim))));
            n_o_done  = w_prior_last;
            if (w_prior_last) begin
                n_state = ST_RUN;
                n_pos   = 2'd0;
            end else begin
                n_pos   = w_pos_eff + 2'd1;
            end
        end

        if (w_drain_fire) begin
            n_o_valid = 1'b1;
            n_o_row   = w_e[1];
            n_o_col   = w_e[0];
            n_o_re    = fmt(r_acc_re[w_e]);
            n_o_im    = fmt(r_acc_im[w_e]);
            n_o_done  = w_drain_last;
            if (w_drain_last)
                n_state = ST_RUN;
            else
                n_k = r_k + 2'd1;
        end

        // tile finished: start the next one from zero
        if ((w_prior_fire & w_prior_last) | (w_drain_fire & w_drain_last)) begin
            for (int e = 0; e < 4; e++) begin
                n_acc_re[e] = '0;
                n_acc_im[e] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < 4; e++) begin
                r_acc_re[e] <= '0;
                r_acc_im[e] <= '0;
            end
            r_state   <= ST_RUN;
            r_pos     <= 2'd0;
            r_k       <= 2'd0;
            r_o_valid <= 1'b0;
        end else begin
            r_acc_re  <= n_acc_re;
            r_acc_im  <= n_acc_im;
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_k       <= n_k;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_row  <= n_o_row;
        r_o_col  <= n_o_col;
        r_o_re   <= n_o_re;
        r_o_im   <= n_o_im;
        r_o_done <= n_o_done;
    end

    assign o_res.valid     = r_o_valid;
    assign o_res.row_index = r_o_row;
    assign o_res.col_index = r_o_col;
    assign o_res.out_re    = r_o_re;
    assign o_res.out_im    = r_o_im;
    assign o_res.tile_done = r_o_done;

endmodule

`default_nettype wire

// File: rtl/core/complex_gemm_tile_2x2_mac.sv
// top level: complex 2x2 gemm tile mac with apb config registers
// path: a beat goes from the queue to the product register; a prior beat then loads
//   the output register; a last step in overwrite mode enters the drain state first
// throughput: one step beat per cycle while the queue is not full; a last step in
//   overwrite mode holds the back end while its elements (up to 4) leave one by one
// reset: synchronous active low; clears queue, accumulators, emit state, output valid,
//   and sets registers to overwrite mode with two rows and two columns
`timescale 1ns / 1ps
`default_nettype none

module complex_gemm_tile_2x2_mac #(
    parameter int DATA_WIDTH = cgt_pkg::DATA_WIDTH_DEF,
    parameter int ACC_WIDTH  = cgt_pkg::ACC_WIDTH_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    cgt_step_if.sink                     i_step,
    cgt_res_if.source                    o_res,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [cgt_pkg::CFG_AW-1:0]    paddr,
    input  wire [cgt_pkg::CFG_DW-1:0]    pwdata,
    output logic [cgt_pkg::CFG_DW-1:0]   prdata,
    output logic                         pready
);
    import cgt_pkg::*;

    // config registers
    logic       r_accum;
    logic [1:0] r_rows;
    logic [1:0] r_cols;
    logic       w_cfg_wr;
    logic [1:0] w_cfg_idx;
    t_tile_cfg  w_cfg;

    // front to back queue head
    logic                       w_q_valid;
    logic                       w_q_ready;
    t_step_ctl                  w_q_ctl;
    logic [7:0][DATA_WIDTH-1:0] w_q_ops;
    logic [PRIOR_W-1:0]         w_q_prior_re;
    logic [PRIOR_W-1:0]         w_q_prior_im;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite & pready;
    assign w_cfg_idx = paddr[CFG_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= 1'b0;
            r_rows  <= 2'd2;
            r_cols  <= 2'd2;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_ACCUM: r_accum <= pwdata[0];
                REG_ROWS:  r_rows  <= pwdata[1:0];
                REG_COLS:  r_cols  <= pwdata[1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            REG_ACCUM: prdata = {{(CFG_DW-1){1'b0}}, r_accum};
            REG_ROWS:  prdata = {{(CFG_DW-2){1'b0}}, r_rows};
            REG_COLS:  prdata = {{(CFG_DW-2){1'b0}}, r_cols};
            default:   prdata = '0;
        endcase
    end

    // two or three both mean two
    assign w_cfg.accum = r_accum;
    assign w_cfg.rows2 = r_rows[1];
    assign w_cfg.cols2 = r_cols[1];

    // front: takes beats into a four deep queue, ready while not full
    cgt_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (i_step),
        .o_q_valid    (w_q_valid),
        .i_q_ready    (w_q_ready),
        .o_q_ctl      (w_q_ctl),
        .o_q_ops      (w_q_ops),
        .o_q_prior_re (w_q_prior_re),
        .o_q_prior_im (w_q_prior_im)
    );

    // back: registered products, then accumulators and emit sequencer
    cgt_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .ACC_WIDTH  (ACC_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_q_valid    (w_q_valid),
        .o_q_ready    (w_q_ready),
        .i_q_ctl      (w_q_ctl),
        .i_q_ops      (w_q_ops),
        .i_q_prior_re (w_q_prior_re),
        .i_q_prior_im (w_q_prior_im),
        .o_res        (o_res)
    );

    // no result beat right after reset
    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_res.valid)
        else $error("result valid right after reset");

    // queue is empty after reset so a beat can be taken at once
    a_reset_ready: assert property (@(posedge i_clk) !i_rst_n |=> i_step.ready)
        else $error("step not ready after reset");

    // a rows write lands in the register
    a_rows_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg_wr && w_cfg_idx == REG_ROWS) |=> r_rows == $past(pwdata[1:0]))
        else $error("rows register write lost");

    // a columns write lands in the register
    a_cols_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg_wr && w_cfg_idx == REG_COLS) |=> r_cols == $past(pwdata[1:0]))
        else $error("cols register write lost");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// self-checking bench for the complex 2x2 gemm tile mac: directed rows, a back-pressure run, then random tiles
`timescale 1ns / 1ps
module tb_top;
    import cgt_pkg::*;

    // request kinds carried in req_type
    localparam bit REQ_STEP  = 1'b0;
    localparam bit REQ_PRIOR = 1'b1;

    localparam longint ACC_MAX   = 64'sd140737488355327;
    localparam longint ACC_MIN   = -64'sd140737488355328;
    localparam int     ITEM_GOAL = 410;
    localparam int     LONG_HOLD = 120;
    localparam int     SETTLE    = 16;

    // one step channel beat
    typedef struct {
        bit                           req;
        logic signed [DATA_WIDTH_DEF-1:0] a0_re, a0_im, a1_re, a1_im;
        logic signed [DATA_WIDTH_DEF-1:0] b0_re, b0_im, b1_re, b1_im;
        bit                           last;
        logic signed [PRIOR_W-1:0]    prior_re, prior_im;
    } t_step_beat;

    // one emitted tile element
    typedef struct {
        bit               row;
        bit               col;
        logic [OUT_W-1:0] re;
        logic [OUT_W-1:0] im;
        bit               done;
    } t_elem;

    typedef enum {ROW_STEP, ROW_CFG} t_row_kind;

    // directed stimulus row: either a register write or a step beat sent reps times
    typedef struct {
        t_row_kind   kind;
        int          reps;
        t_step_beat  beat;
        logic [1:0]  reg_idx;
        logic [31:0] reg_val;
        bit          typed;
        t_elem       want;
    } t_dir_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    cgt_step_if step_bus ();
    cgt_res_if  res_bus ();

    complex_gemm_tile_2x2_mac dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // mirror of the tile state: element e = 2*row + col
    longint     acc_re [4];
    longint     acc_im [4];
    bit         awaiting;
    int         emit_pos;
    bit         cfg_accum;
    logic [1:0] cfg_rows;
    logic [1:0] cfg_cols;

    t_elem      tile_out_q [$];   // elements owed by the block, oldest first
    t_dir_row   dir_rows [$];
    t_elem      no_elem;
    t_elem      head;
    int         sent;             // beats accepted by the block
    int         errs;
    int         burst_left;
    bit         hold_now;

    // clock, 10 ns period
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop if something hangs
    initial begin
        #3_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic longint sat48(input longint v);
        if (v > ACC_MAX) return ACC_MAX;
        if (v < ACC_MIN) return ACC_MIN;
        return v;
    endfunction

    function automatic void clear_tile();
        for (int e = 0; e < 4; e++) begin
            acc_re[e] = 0;
            acc_im[e] = 0;
        end
    endfunction

    // advance the tile mirror by one accepted beat, return the elements it emits
    function automatic int apply_step(input t_step_beat s, output t_elem made [4]);
        int     nr, nc, cnt, k, pos, e;
        longint ar [2], ai [2], br [2], bi [2];
        longint pre, pim;
        nr  = (cfg_rows >= 2) ? 2 : 1;
        nc  = (cfg_cols >= 2) ? 2 : 1;
        cnt = nr * nc;
        k   = 0;
        if (s.req == REQ_STEP) begin
            // multiply steps are dropped while priors are pending
            if (awaiting) return 0;
            ar[0] = s.a0_re; ai[0] = s.a0_im; ar[1] = s.a1_re; ai[1] = s.a1_im;
            br[0] = s.b0_re; bi[0] = s.b0_im; br[1] = s.b1_re; bi[1] = s.b1_im;
            // unused rows and columns keep their accumulators
            for (int r = 0; r < nr; r++) begin
                for (int c = 0; c < nc; c++) begin
                    e = 2 * r + c;
                    // each partial product saturates on its own
                    acc_re[e] = sat48(acc_re[e] + ar[r] * br[c]);
                    acc_re[e] = sat48(acc_re[e] - ai[r] * bi[c]);
                    acc_im[e] = sat48(acc_im[e] + ai[r] * br[c]);
                    acc_im[e] = sat48(acc_im[e] + ar[r] * bi[c]);
                end
            end
            if (!s.last) return 0;
            // accumulate mode: the tile leaves later, one element per prior
            if (cfg_accum) begin
                awaiting = 1'b1;
                emit_pos = 0;
                return 0;
            end
            for (int r = 0; r < nr; r++) begin
                for (int c = 0; c < nc; c++) begin
                    e = 2 * r + c;
                    made[k].row  = (r == 1);
                    made[k].col  = (c == 1);
                    made[k].re   = acc_re[e][OUT_W-1:0];
                    made[k].im   = acc_im[e][OUT_W-1:0];
                    made[k].done = (k + 1 == cnt);
                    k++;
                end
            end
            clear_tile();
            return k;
        end
        // a prior with nothing pending is dropped
        if (!awaiting) return 0;
        // a position past the used count after a shrink lands on the last element
        pos = (emit_pos >= cnt) ? cnt - 1 : emit_pos;
        e   = 2 * (pos / nc) + pos % nc;
        pre = s.prior_re;
        pim = s.prior_im;
        made[0].row  = ((pos / nc) == 1);
        made[0].col  = ((pos % nc) == 1);
        made[0].re   = OUT_W'(sat48(pre + acc_re[e]));
        made[0].im   = OUT_W'(sat48(pim + acc_im[e]));
        made[0].done = (pos + 1 == cnt);
        if (pos + 1 == cnt) begin
            clear_tile();
            awaiting = 1'b0;
            emit_pos = 0;
        end else begin
            emit_pos = (pos + 1) % 4;
        end
        return 1;
    endfunction

    function automatic t_dir_row step_row(input int ar0, ai0, ar1, ai1,
                                          input int br0, bi0, br1, bi1,
                                          input bit last, input int reps = 1);
        t_dir_row d;
        d.kind          = ROW_STEP;
        d.reps          = reps;
        d.typed         = 1'b0;
        d.beat.req      = REQ_STEP;
        d.beat.a0_re    = 16'(ar0);
        d.beat.a0_im    = 16'(ai0);
        d.beat.a1_re    = 16'(ar1);
        d.beat.a1_im    = 16'(ai1);
        d.beat.b0_re    = 16'(br0);
        d.beat.b0_im    = 16'(bi0);
        d.beat.b1_re    = 16'(br1);
        d.beat.b1_im    = 16'(bi1);
        d.beat.last     = last;
        // prior fields are don't-care on a step, drive them to a loud pattern
        d.beat.prior_re = ACC_MIN[PRIOR_W-1:0];
        d.beat.prior_im = ACC_MAX[PRIOR_W-1:0];
        return d;
    endfunction

    function automatic t_dir_row prior_row(input longint pre, pim, input bit last);
        t_dir_row d;
        // operand fields ignored on a prior beat
        d = step_row(-32768, 32767, -1, 1, 32767, -32768, -1, 1, last);
        d.beat.req      = REQ_PRIOR;
        d.beat.prior_re = pre[PRIOR_W-1:0];
        d.beat.prior_im = pim[PRIOR_W-1:0];
        return d;
    endfunction

    function automatic t_dir_row cfg_row(input logic [1:0] idx, input logic [31:0] val);
        t_dir_row d;
        d.kind    = ROW_CFG;
        d.reps    = 0;
        d.reg_idx = idx;
        d.reg_val = val;
        d.typed   = 1'b0;
        return d;
    endfunction

    // attach a hand-worked single element to a step row
    function automatic t_dir_row with_elem(input t_dir_row d, input longint re, im);
        d.typed     = 1'b1;
        d.want.row  = 1'b0;
        d.want.col  = 1'b0;
        d.want.re   = re[OUT_W-1:0];
        d.want.im   = im[OUT_W-1:0];
        d.want.done = 1'b1;
        return d;
    endfunction

    // operands biased toward the extremes
    function automatic logic [15:0] rnd16();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [47:0] rnd48();
        case ($urandom_range(0, 5))
            0:       return ACC_MAX[47:0];
            1:       return ACC_MIN[47:0];
            2:       return {16'h0000, 32'($urandom)};
            3:       return {16'hffff, 32'($urandom)};
            default: return {16'($urandom), 32'($urandom)};
        endcase
    endfunction

    function automatic t_step_beat rand_beat(input bit req, input bit last);
        t_step_beat s;
        s.req      = req;
        s.a0_re    = rnd16();
        s.a0_im    = rnd16();
        s.a1_re    = rnd16();
        s.a1_im    = rnd16();
        s.b0_re    = rnd16();
        s.b0_im    = rnd16();
        s.b1_re    = rnd16();
        s.b1_im    = rnd16();
        s.last     = last;
        s.prior_re = rnd48();
        s.prior_im = rnd48();
        return s;
    endfunction

    // drive one beat from a falling edge, hold until taken, record what it owes
    task automatic send_beat(input t_step_beat s, input bit typed, input t_elem te);
        t_elem made [4];
        int    n;
        step_bus.valid     <= 1'b1;
        step_bus.req_type  <= s.req;
        step_bus.a0_re     <= s.a0_re;
        step_bus.a0_im     <= s.a0_im;
        step_bus.a1_re     <= s.a1_re;
        step_bus.a1_im     <= s.a1_im;
        step_bus.b0_re     <= s.b0_re;
        step_bus.b0_im     <= s.b0_im;
        step_bus.b1_re     <= s.b1_re;
        step_bus.b1_im     <= s.b1_im;
        step_bus.last_step <= s.last;
        step_bus.prior_re  <= s.prior_re;
        step_bus.prior_im  <= s.prior_im;
        do @(posedge i_clk); while (!step_bus.ready);
        sent++;
        n = apply_step(s, made);
        if (typed) begin
            tile_out_q.push_back(te);
        end else begin
            for (int k = 0; k < n; k++) tile_out_q.push_back(made[k]);
        end
        @(negedge i_clk);
    endtask

    // sender in bursts with random gaps between them
    task automatic offer(input t_step_beat s, input bit typed, input t_elem te);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 50)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
                step_bus.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        send_beat(s, typed, te);
    endtask

    // stop offering and let every owed element drain, then settle
    task automatic wait_quiet();
        step_bus.valid <= 1'b0;
        wait (tile_out_q.size() == 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // apb write: setup, access, then idle
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_ACCUM: cfg_accum = val[0];
            REG_ROWS:  cfg_rows  = val[1:0];
            REG_COLS:  cfg_cols  = val[1:0];
            default:   ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic void cmp_field(input string name, input logic [47:0] want, got);
        if (got !== want) begin
            $error("%s expected %0d got %0d", name, $signed(want), $signed(got));
            errs++;
        end
    endfunction

    // result side: every accepted beat is matched against the oldest owed element
    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (tile_out_q.size() == 0) begin
                $error("result beat with no element owed");
                errs++;
            end else begin
                head = tile_out_q.pop_front();
                cmp_field("row_index", 48'(head.row), 48'(res_bus.row_index));
                cmp_field("col_index", 48'(head.col), 48'(res_bus.col_index));
                cmp_field("out_re", head.re, res_bus.out_re);
                cmp_field("out_im", head.im, res_bus.out_im);
                cmp_field("tile_done", 48'(head.done), 48'(res_bus.tile_done));
            end
        end
    end

    // receiver: changing stall pattern, plus one long hold-off on request
    initial begin
        int hold_left;
        int mode;
        int mode_left;
        int tick;
        hold_left = 0;
        mode      = 0;
        mode_left = 0;
        tick      = 0;
        res_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            tick++;
            if (hold_left > 0) begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end else if (hold_now) begin
                hold_now  = 1'b0;
                hold_left = LONG_HOLD;
                res_bus.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(8, 64);
                end
                mode_left--;
                case (mode)
                    0:       res_bus.ready <= 1'b1;
                    1:       res_bus.ready <= ($urandom_range(0, 2) != 0);
                    default: res_bus.ready <= (tick % 3 == 0);
                endcase
            end
        end
    end

    // stimulus
    initial begin
        int         nsteps;
        int         nprior;
        logic [1:0] r_sel;
        logic [1:0] c_sel;
        bit         a_sel;

        // every input known from time zero
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        step_bus.valid     = 1'b0;
        step_bus.req_type  = REQ_STEP;
        step_bus.a0_re     = '0;
        step_bus.a0_im     = '0;
        step_bus.a1_re     = '0;
        step_bus.a1_im     = '0;
        step_bus.b0_re     = '0;
        step_bus.b0_im     = '0;
        step_bus.b1_re     = '0;
        step_bus.b1_im     = '0;
        step_bus.last_step = 1'b0;
        step_bus.prior_re  = '0;
        step_bus.prior_im  = '0;
        no_elem            = '{default: '0};
        errs               = 0;
        sent               = 0;
        burst_left         = 0;
        hold_now           = 1'b0;

        // mirror starts at the reset state: overwrite, two rows, two columns
        clear_tile();
        awaiting  = 1'b0;
        emit_pos  = 0;
        cfg_accum = 1'b0;
        cfg_rows  = 2'd2;
        cfg_cols  = 2'd2;

        // directed rows
        // full 2x2 tile straight out of reset
        dir_rows.push_back(step_row(16384, 0, -16384, 8192, 16384, -16384, 32767, -32768, 1));
        // single element, unused operands at extremes must not leak in
        dir_rows.push_back(cfg_row(REG_ROWS, 32'd1));
        dir_rows.push_back(cfg_row(REG_COLS, 32'd1));
        // (-1) * (-1) on the real parts
        dir_rows.push_back(with_elem(step_row(-32768, 0, 32767, 32767,
                                              -32768, 0, -32768, -32768, 1),
                                     64'sd1073741824, 64'sd0));
        // j * j on the imaginary parts subtracts
        dir_rows.push_back(with_elem(step_row(0, -32768, -32768, -32768,
                                              0, -32768, 32767, 32767, 1),
                                     -64'sd1073741824, 64'sd0));
        // two-step inner dimension
        dir_rows.push_back(step_row(32767, -32768, 0, 0, -32768, 32767, 0, 0, 0));
        dir_rows.push_back(step_row(32767, -32768, 0, 0, -32768, 32767, 0, 0, 1));
        // prior while nothing pending: dropped
        dir_rows.push_back(prior_row(ACC_MAX, ACC_MIN, 1'b1));
        // one row, two columns
        dir_rows.push_back(cfg_row(REG_COLS, 32'd2));
        dir_rows.push_back(step_row(12345, -2222, 0, 0, -32768, 32767, 32767, -32768, 1));
        // out-of-range encodings: 3 rows means two, 0 columns means one
        dir_rows.push_back(cfg_row(REG_ROWS, 32'd3));
        dir_rows.push_back(cfg_row(REG_COLS, 32'd0));
        dir_rows.push_back(step_row(-32768, 32767, 32767, -32768, 1111, -1, 0, 0, 1));
        // accumulate mode on a full tile
        dir_rows.push_back(cfg_row(REG_ACCUM, 32'd1));
        dir_rows.push_back(cfg_row(REG_ROWS, 32'd2));
        dir_rows.push_back(cfg_row(REG_COLS, 32'd2));
        dir_rows.push_back(step_row(1000, 2000, -3000, 4000, 5000, -6000, 7000, -8000, 0));
        dir_rows.push_back(step_row(-32768, -32768, 32767, 32767,
                                    -32768, 32767, 32767, -32768, 1));
        // step while priors are pending: dropped
        dir_rows.push_back(step_row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 1));
        dir_rows.push_back(prior_row(ACC_MAX, ACC_MAX, 1'b0));
        dir_rows.push_back(prior_row(ACC_MIN, ACC_MIN, 1'b1));
        // shrink the tile mid-emit: position two lands on the only element and ends it
        dir_rows.push_back(cfg_row(REG_ROWS, 32'd1));
        dir_rows.push_back(cfg_row(REG_COLS, 32'd1));
        dir_rows.push_back(prior_row(64'sd123456789, -64'sd987654321, 1'b0));
        // priors at both rails push the sums into saturation
        dir_rows.push_back(cfg_row(REG_ROWS, 32'd2));
        dir_rows.push_back(cfg_row(REG_COLS, 32'd2));
        dir_rows.push_back(step_row(-32768, -32768, 32767, 32767,
                                    -32768, 32767, 32767, -32768, 1));
        dir_rows.push_back(prior_row(ACC_MAX, ACC_MAX, 1'b0));
        dir_rows.push_back(prior_row(ACC_MIN, ACC_MIN, 1'b0));
        dir_rows.push_back(prior_row(64'sd0, 64'sd0, 1'b1));
        dir_rows.push_back(prior_row(-64'sd1, 64'sd1, 1'b0));
        dir_rows.push_back(cfg_row(REG_ACCUM, 32'd0));

        // reset asserted from time zero, released on a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                wait_quiet();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end else if (dir_rows[i].reps > 1) begin
                // back to back, no gaps, to keep the long run short
                repeat (dir_rows[i].reps) send_beat(dir_rows[i].beat, 1'b0, no_elem);
            end else begin
                offer(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        // back-pressure: receiver holds off while full tiles keep coming
        wait_quiet();
        write_reg(REG_ACCUM, 32'd0);
        write_reg(REG_ROWS, 32'd2);
        write_reg(REG_COLS, 32'd2);
        hold_now = 1'b1;
        repeat (12) send_beat(rand_beat(REQ_STEP, 1'b1), 1'b0, no_elem);
        wait_quiet();

        // random phases: new setting, then a handful of well-formed tiles with noise mixed in
        while (sent < ITEM_GOAL) begin
            a_sel = 1'($urandom_range(0, 1));
            r_sel = 2'($urandom_range(0, 3));
            c_sel = 2'($urandom_range(0, 3));
            wait_quiet();
            write_reg(REG_ACCUM, {31'd0, a_sel});
            write_reg(REG_ROWS, {30'd0, r_sel});
            write_reg(REG_COLS, {30'd0, c_sel});
            repeat ($urandom_range(2, 6)) begin
                // stray prior with nothing pending
                if ($urandom_range(0, 11) == 0)
                    offer(rand_beat(REQ_PRIOR, 1'($urandom_range(0, 1))), 1'b0, no_elem);
                nsteps = $urandom_range(1, 5);
                for (int s = 0; s < nsteps; s++)
                    offer(rand_beat(REQ_STEP, s == nsteps - 1), 1'b0, no_elem);
                if (cfg_accum) begin
                    // stray step while priors are pending
                    if ($urandom_range(0, 9) == 0)
                        offer(rand_beat(REQ_STEP, 1'($urandom_range(0, 1))), 1'b0, no_elem);
                    nprior = ((cfg_rows >= 2) ? 2 : 1) * ((cfg_cols >= 2) ? 2 : 1);
                    if ($urandom_range(0, 9) == 0) nprior++;
                    repeat (nprior)
                        offer(rand_beat(REQ_PRIOR, 1'($urandom_range(0, 1))), 1'b0,
                              no_elem);
                end
            end
        end

        // drain, then give stray beats a chance to show up
        wait_quiet();
        repeat (20) @(posedge i_clk);
        if (errs == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/cgt_pkg.sv
rtl/core/cgt_ifs.sv
rtl/core/cgt_front.sv
rtl/core/cgt_back.sv
rtl/core/complex_gemm_tile_2x2_mac.sv
sim/tb_top.sv
